>>> rtl/core/tdcp_pkg.sv
package tdcp_pkg;

   localparam int NUM_TAGS = 5;
   localparam int TAG_W = 3;
   localparam int SPEED_W = 16;

   localparam logic [TAG_W-1:0] TAG_L    = 3'd0;
   localparam logic [TAG_W-1:0] TAG_R    = 3'd1;
   localparam logic [TAG_W-1:0] TAG_A    = 3'd2;
   localparam logic [TAG_W-1:0] TAG_D    = 3'd3;
   localparam logic [TAG_W-1:0] TAG_G    = 3'd4;
   localparam logic [TAG_W-1:0] TAG_NONE = 3'd7;

   localparam logic [7:0] CHAR_E    = 8'h45;
   localparam logic [7:0] CHAR_L    = 8'h4C;
   localparam logic [7:0] CHAR_R    = 8'h52;
   localparam logic [7:0] CHAR_A    = 8'h41;
   localparam logic [7:0] CHAR_D    = 8'h44;
   localparam logic [7:0] CHAR_G    = 8'h47;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   localparam logic [SPEED_W-1:0] RESET_SPEED = 16'd90;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       timeout;
   } item_type;

   typedef struct packed {
      logic [SPEED_W-1:0] left_speed;
      logic [SPEED_W-1:0] right_speed;
      logic [SPEED_W-1:0] vertical_speed;
      logic               leds_on;
      logic [SPEED_W-1:0] gripper_command;
      logic               gripper_valid;
   } result_type;

   typedef struct packed {
      logic                 we;
      logic [SPEED_W-1:0]   data;
   } csr_type;

   function automatic logic [TAG_W-1:0] tag_of(input logic [7:0] b);
      logic [TAG_W-1:0] t;
      unique case (b)
         CHAR_L:  t = TAG_L;
         CHAR_R:  t = TAG_R;
         CHAR_A:  t = TAG_A;
         CHAR_D:  t = TAG_D;
         CHAR_G:  t = TAG_G;
         default: t = TAG_NONE;
      endcase
      return t;
   endfunction

   // value * 10 + digit, clamped to 16 bits
   function automatic logic [SPEED_W-1:0] acc_digit(input logic [SPEED_W-1:0] v,
                                                    input logic [3:0] d);
      logic [19:0] acc;
      acc = ({4'd0, v} << 3) + ({4'd0, v} << 1) + {16'd0, d};
      return (acc[19:16] != 4'd0) ? {SPEED_W{1'b1}} : acc[SPEED_W-1:0];
   endfunction

endpackage

>>> rtl/core/tagged_decimal_command_parser.sv
// Parses remote-control messages one received byte per transaction. Tags L, R, A, D
// and G take the decimal digits that follow (first occurrence per message only,
// saturating at 65535); E or a timeout transaction ends the message and yields one
// result transaction with the motor speeds, LED flag and gripper command. The block
// takes one byte every clock cycle unless the input is held off; a byte passes an
// input register and the message-state update, and the result of an ending byte is
// loaded into the result register when that byte leaves the input register. An E or
// timeout byte waits in the input register while an earlier result is still held
// and not taken, and the input is held off meanwhile; other bytes never wait. The
// per-byte rate is set by the update of the message state register.
// A csr write loads all three held motor speeds.
module tagged_decimal_command_parser
   import tdcp_pkg::*;
#(
   parameter int MAX_BYTES = 22
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [0:0]  req_tuser,   // [0] timeout
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] left_speed, [31:16] right_speed, [47:32] vertical_speed, [48] leds_on,
   // [64:49] gripper_command, [65] gripper_valid, [71:66] zero
   output logic [71:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff, in_item_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;

   logic       go;
   logic       done;
   logic       out_free;
   logic       needs_out;
   logic       advance;
   result_type result;
   csr_type    csr;

   tdcp_parser #(
      .MAX_BYTES(MAX_BYTES)
   ) u_parser (
      .clock (clock),
      .reset (reset),
      .go    (go),
      .item  (in_item_ff),
      .csr   (csr),
      .done  (done),
      .result(result)
   );

   always_comb begin
      csr.we    = csr_valid;
      csr.data  = csr_data;
      csr_ready = 1'b1;

      out_free  = !out_valid_ff || rsp_tready;
      needs_out = in_item_ff.timeout || (in_item_ff.rx_byte == CHAR_E);
      advance   = in_valid_ff && (!needs_out || out_free);
      go        = advance;
      req_tready = !in_valid_ff || advance;

      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_tready) begin
         in_valid_in        = req_tvalid;
         in_item_in.rx_byte = req_tdata;
         in_item_in.timeout = req_tuser[0];
      end

      out_valid_in = out_valid_ff && !rsp_tready;
      out_in       = out_ff;
      if (done) begin
         out_valid_in = 1'b1;
         out_in       = result;
      end

      rsp_tvalid = out_valid_ff;
      rsp_tdata  = {6'd0, out_ff.gripper_valid, out_ff.gripper_command, out_ff.leds_on,
                    out_ff.vertical_speed, out_ff.right_speed, out_ff.left_speed};
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      out_ff     <= out_in;
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

>>> rtl/core/tdcp_parser.sv
module tdcp_parser
   import tdcp_pkg::*;
#(
   parameter int MAX_BYTES = 22
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       go,
   input  item_type   item,
   input  csr_type    csr,
   output logic       done,
   output result_type result
);

   localparam int CNT_W = $clog2(MAX_BYTES + 1);

   logic [SPEED_W-1:0] vals_ff [NUM_TAGS];
   logic [SPEED_W-1:0] vals_in [NUM_TAGS];
   logic [NUM_TAGS-1:0] seen_ff, seen_in;
   logic [TAG_W-1:0]    active_ff, active_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [SPEED_W-1:0]  left_ff, left_in, right_ff, right_in, vert_ff, vert_in;
   logic                leds_ff, leds_in;

   logic             is_digit;
   logic             in_window;
   logic             finish;
   logic [TAG_W-1:0] tag;
   logic [3:0]       digit;

   always_comb begin
      is_digit  = (item.rx_byte >= CHAR_ZERO) && (item.rx_byte <= CHAR_NINE);
      digit     = 4'(item.rx_byte - CHAR_ZERO);
      in_window = count_ff < CNT_W'(MAX_BYTES);
      tag       = tag_of(item.rx_byte);
      finish    = go && (item.timeout || (item.rx_byte == CHAR_E));

      vals_in   = vals_ff;
      seen_in   = seen_ff;
      active_in = active_ff;
      count_in  = count_ff;

      if (go && !item.timeout && in_window) begin
         count_in = count_ff + CNT_W'(1);
         if (is_digit) begin
            for (int i = 0; i < NUM_TAGS; i++) begin
               if (active_ff == TAG_W'(i)) begin
                  vals_in[i] = acc_digit(vals_ff[i], digit);
               end
            end
         end else begin
            active_in = TAG_NONE;
            for (int i = 0; i < NUM_TAGS; i++) begin
               if (tag == TAG_W'(i) && !seen_ff[i]) begin
                  seen_in[i] = 1'b1;
                  vals_in[i] = '0;
                  active_in  = tag;
               end
            end
         end
      end

      // an E byte touches neither seen bits nor values, so finish reads current state
      left_in  = (finish && seen_ff[TAG_L]) ? vals_ff[TAG_L] : left_ff;
      right_in = (finish && seen_ff[TAG_R]) ? vals_ff[TAG_R] : right_ff;
      vert_in  = (finish && seen_ff[TAG_A]) ? vals_ff[TAG_A] : vert_ff;
      leds_in  = (finish && seen_ff[TAG_D]) ? (vals_ff[TAG_D] != '0) : leds_ff;

      if (csr.we) begin
         left_in  = csr.data;
         right_in = csr.data;
         vert_in  = csr.data;
      end

      if (finish) begin
         seen_in   = '0;
         active_in = TAG_NONE;
         count_in  = '0;
      end

      done                   = finish;
      result.left_speed      = left_in;
      result.right_speed     = right_in;
      result.vertical_speed  = vert_in;
      result.leds_on         = leds_in;
      result.gripper_valid   = seen_ff[TAG_G];
      result.gripper_command = seen_ff[TAG_G] ? vals_ff[TAG_G] : '0;
   end

   always_ff @(posedge clock) begin
      vals_ff <= vals_in;
      if (reset) begin
         seen_ff   <= '0;
         active_ff <= TAG_NONE;
         count_ff  <= '0;
         left_ff   <= RESET_SPEED;
         right_ff  <= RESET_SPEED;
         vert_ff   <= RESET_SPEED;
         leds_ff   <= 1'b0;
      end else begin
         seen_ff   <= seen_in;
         active_ff <= active_in;
         count_ff  <= count_in;
         left_ff   <= left_in;
         right_ff  <= right_in;
         vert_ff   <= vert_in;
         leds_ff   <= leds_in;
      end
   end

endmodule

>>> tb/sv/tb_tagged_decimal_command_parser.sv
`timescale 1ns / 100ps

module tb_tagged_decimal_command_parser;
   import tdcp_pkg::*;

   localparam int MSG_LIMIT   = 22;
   localparam int IDLE_PCT    = 30;
   localparam int SETTLE      = 8;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 380;

   localparam logic [7:0] TAG_CHARS [NUM_TAGS] = '{CHAR_L, CHAR_R, CHAR_A, CHAR_D, CHAR_G};
   localparam logic [7:0] FILLERS [4] = '{8'h20, 8'h2B, 8'h2D, 8'h2C};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   // byte stream waiting for the driver, and motor reports waiting for the DUT
   item_type   rx_queue[$];
   result_type motor_reports[$];

   // parser shadow state
   logic [15:0]         left_hold = RESET_SPEED;
   logic [15:0]         right_hold = RESET_SPEED;
   logic [15:0]         vert_hold = RESET_SPEED;
   logic                leds_hold = 1'b0;
   logic [15:0]         tag_acc [NUM_TAGS] = '{default: '0};
   logic [NUM_TAGS-1:0] tags_seen = '0;
   logic [TAG_W-1:0]    cur_tag = TAG_NONE;
   int unsigned         msg_bytes = 0;

   bit          calm = 1'b0;
   int unsigned queued = 0;
   int unsigned accepted = 0;
   int unsigned checked = 0;
   int unsigned grip_msgs = 0;
   int unsigned timeout_msgs = 0;
   int unsigned csr_writes = 0;
   int unsigned errors = 0;
   int unsigned cycles = 0;

   tagged_decimal_command_parser #(.MAX_BYTES(MSG_LIMIT)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial forever #5 clock = ~clock;

   task automatic parse_rx_item(input item_type it);
      result_type       r;
      logic [TAG_W-1:0] hit;
      int unsigned      acc;
      int               t;
      if (!it.timeout && msg_bytes < MSG_LIMIT) begin
         msg_bytes++;
         if (it.rx_byte >= CHAR_ZERO && it.rx_byte <= CHAR_NINE) begin
            if (cur_tag != TAG_NONE) begin
               acc = 32'(tag_acc[cur_tag]) * 32'd10 + 32'(it.rx_byte - CHAR_ZERO);
               tag_acc[cur_tag] = (acc > 65535) ? 16'hFFFF : acc[15:0];
            end
         end else begin
            hit = TAG_NONE;
            for (t = 0; t < NUM_TAGS; t++)
               if (it.rx_byte == TAG_CHARS[t]) hit = t[TAG_W-1:0];
            cur_tag = TAG_NONE;
            // a repeated tag letter only terminates the running number
            if (hit != TAG_NONE && !tags_seen[hit]) begin
               tags_seen[hit] = 1'b1;
               tag_acc[hit] = '0;
               cur_tag = hit;
            end
         end
      end
      if (it.timeout || it.rx_byte == CHAR_E) begin
         if (tags_seen[TAG_L]) left_hold = tag_acc[TAG_L];
         if (tags_seen[TAG_R]) right_hold = tag_acc[TAG_R];
         if (tags_seen[TAG_A]) vert_hold = tag_acc[TAG_A];
         if (tags_seen[TAG_D]) leds_hold = (tag_acc[TAG_D] != 16'd0);
         r.left_speed = left_hold;
         r.right_speed = right_hold;
         r.vertical_speed = vert_hold;
         r.leds_on = leds_hold;
         r.gripper_valid = tags_seen[TAG_G];
         r.gripper_command = tags_seen[TAG_G] ? tag_acc[TAG_G] : '0;
         motor_reports.push_back(r);
         if (tags_seen[TAG_G]) grip_msgs++;
         if (it.timeout) timeout_msgs++;
         tag_acc = '{default: '0};
         tags_seen = '0;
         cur_tag = TAG_NONE;
         msg_bytes = 0;
      end
   endtask

   task automatic note_mismatch(input string msg);
      errors++;
      if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got)
         note_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
   endtask

   // driver: one transaction per handshake, random idle cycles unless calm
   always @(posedge clock) begin
      item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            accepted++;
            nxt.rx_byte = req_tdata;
            nxt.timeout = req_tuser[0];
            parse_rx_item(nxt);
         end
         if (!req_tvalid || req_tready) begin
            if (rx_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
               nxt = rx_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= nxt.rx_byte;
               req_tuser <= nxt.timeout;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: compares every result transaction against the oldest report
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (motor_reports.size() == 0) begin
               note_mismatch($sformatf("result with nothing pending, data %h", rsp_tdata));
            end else begin
               want = motor_reports.pop_front();
               checked++;
               check_field("left_speed", 32'(want.left_speed), 32'(rsp_tdata[15:0]));
               check_field("right_speed", 32'(want.right_speed), 32'(rsp_tdata[31:16]));
               check_field("vertical_speed", 32'(want.vertical_speed),
                           32'(rsp_tdata[47:32]));
               check_field("leds_on", 32'(want.leds_on), 32'(rsp_tdata[48]));
               check_field("gripper_command", 32'(want.gripper_command),
                           32'(rsp_tdata[64:49]));
               check_field("gripper_valid", 32'(want.gripper_valid), 32'(rsp_tdata[65]));
            end
         end
         rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d reports pending", cycles, motor_reports.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic push_rx(input logic [7:0] b, input logic to);
      item_type it;
      it.rx_byte = b;
      it.timeout = to;
      rx_queue.push_back(it);
      queued++;
   endtask

   task automatic push_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) push_rx(s[i], 1'b0);
   endtask

   task automatic push_digits();
      int r;
      int n;
      int i;
      r = $urandom_range(99);
      if (r < 10) n = 0;
      else if (r < 75) n = $urandom_range(3, 1);
      else if (r < 90) n = $urandom_range(5, 4);
      else n = $urandom_range(8, 6);
      for (i = 0; i < n; i++) push_rx(CHAR_ZERO + 8'($urandom_range(9)), 1'b0);
   endtask

   task automatic queue_message();
      logic [TAG_W-1:0] order [NUM_TAGS];
      logic [TAG_W-1:0] tmp;
      int j;
      int k;
      int r;
      r = $urandom_range(99);
      // line noise: arbitrary bytes, occasionally a timeout
      if (r < 12) begin
         k = $urandom_range(10, 1);
         for (j = 0; j < k; j++) push_rx(8'($urandom_range(255)), $urandom_range(19) == 0);
         return;
      end
      for (j = 0; j < NUM_TAGS; j++) order[j] = j[TAG_W-1:0];
      for (j = NUM_TAGS - 1; j > 0; j--) begin
         k = $urandom_range(j);
         tmp = order[j];
         order[j] = order[k];
         order[k] = tmp;
      end
      if ($urandom_range(9) == 0) push_rx(FILLERS[0], 1'b0);
      for (j = 0; j < NUM_TAGS; j++) begin
         if ($urandom_range(99) < 65) begin
            push_rx(TAG_CHARS[order[j]], 1'b0);
            push_digits();
            r = $urandom_range(99);
            if (r < 8) begin
               push_rx(FILLERS[$urandom_range(3)], 1'b0);
            end else if (r < 14) begin
               push_rx(TAG_CHARS[order[j]], 1'b0);
               push_digits();
            end
         end
      end
      // overrun the message byte limit now and then so that E can land past it
      if ($urandom_range(19) == 0)
         for (j = 0; j < 20; j++) push_rx(CHAR_ZERO + 8'($urandom_range(9)), 1'b0);
      if ($urandom_range(99) < 85) push_rx(CHAR_E, 1'b0);
      else push_rx(8'($urandom_range(255)), 1'b1);
   endtask

   task automatic wait_drained();
      while (rx_queue.size() != 0 || req_tvalid || motor_reports.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_neutral(input logic [15:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      left_hold = v;
      right_hold = v;
      vert_hold = v;
      csr_writes++;
   endtask

   task automatic run_phase();
      int unsigned start;
      start = queued;
      while (queued - start < PHASE_ITEMS / 2) queue_message();
      // sender holds off here until every report is back
      wait_drained();
      while (queued - start < PHASE_ITEMS) queue_message();
      wait_drained();
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty message ended by timeout
      push_rx(8'hFF, 1'b1);
      // bare tag is zero, LED on, gripper with a leading zero
      push_text("LD1G05E");
      // saturation, sign as separator, repeated tag ignored
      push_text("R99999-R3E");
      // zero byte ends the number; byte under a timeout is ignored
      push_rx(CHAR_A, 1'b0);
      push_rx(8'h00, 1'b0);
      push_rx(CHAR_ZERO + 8'd4, 1'b0);
      push_rx(CHAR_E, 1'b1);
      wait_drained();
      repeat (SETTLE) @(posedge clock);

      run_phase();
      write_neutral(16'h0000);
      run_phase();
      write_neutral(16'hFFFF);
      run_phase();
      write_neutral(16'($urandom_range(65535)));
      calm = 1'b1;
      run_phase();
      calm = 1'b0;
      write_neutral(16'($urandom_range(65535)));
      run_phase();

      if (motor_reports.size() != 0)
         note_mismatch($sformatf("%0d reports never arrived", motor_reports.size()));
      $display("%0d bytes accepted, %0d messages checked (%0d with gripper, %0d by timeout)",
               accepted, checked, grip_msgs, timeout_msgs);
      $display("%0d neutral speed writes, %0d mismatches", csr_writes, errors);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> tagged_decimal_command_parser.f
rtl/core/tdcp_pkg.sv
rtl/core/tdcp_parser.sv
rtl/core/tagged_decimal_command_parser.sv
tb/sv/tb_tagged_decimal_command_parser.sv
